[rtl/core/pqi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal input qualifier package
// Shared types and constants: pedal modes, register indexes, reset values
// and the fixed-point format of the expression position.
// ----------------------------------------------------------------------------
package pqi_pkg;

    // Accepted and detected pedal modes.
    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SWITCH = 2'd1,
        MODE_EXPR   = 2'd2
    } pedal_mode_t;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_SLEEVE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TIP_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TIP_HI = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEEL          = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOE           = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_HOLD     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HOLD    = 4'd7;

    // Register widths.
    localparam int unsigned LEVEL_W = 10;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned STAMP_W = 32;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] RST_DISCONNECT    = 10'd1000;
    localparam logic [LEVEL_W-1:0] RST_SWITCH_SLEEVE = 10'd100;
    localparam logic [LEVEL_W-1:0] RST_SWITCH_TIP_LO = 10'd100;
    localparam logic [LEVEL_W-1:0] RST_SWITCH_TIP_HI = 10'd900;
    localparam logic [LEVEL_W-1:0] RST_HEEL          = 10'd100;
    localparam logic [LEVEL_W-1:0] RST_TOE           = 10'd900;
    localparam logic [HOLD_W-1:0]  RST_MODE_HOLD     = 16'd250;
    localparam logic [HOLD_W-1:0]  RST_PRESS_HOLD    = 16'd30;

    // Position format: Q16 with full toe at exactly one.
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned POS_W     = FRAC_BITS + 1;
    localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

endpackage

[rtl/core/pedal_input_qualifier_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal input qualifier
// Filters a sleeve and tip sample pair, classifies the pedal, debounces the
// mode and the switch press by timestamps and reports the expression position.
// ----------------------------------------------------------------------------
// Sequence: a request is captured, the filters are updated, the mode and the
// press are debounced, the expression position may pass through the serial
// divider, and the result is registered on the output. The block handles one
// request at a time and takes no new one until its result is loaded.
// Reset: synchronous active-low aresetn restores register defaults, clears the
// filters, debounce state and output valid.
module pedal_input_qualifier_unit #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pqi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pqi_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Sample requests.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: sleeve_sample, tip_sample, now_ms, zero fill.
    input  logic [((2*SAMPLE_BITS+32+7)/8)*8-1:0] s_tdata,
    // Results.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: pedal_mode, pressed, mode_changed, press_changed,
    // position_q16, sleeve_filtered, tip_filtered, zero fill.
    output logic [((2*SAMPLE_BITS+22+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned SW = SAMPLE_BITS;
    localparam int unsigned CW = (SAMPLE_BITS > pqi_pkg::LEVEL_W) ? SAMPLE_BITS
                                                                   : pqi_pkg::LEVEL_W;
    localparam int unsigned OUT_W = ((2*SAMPLE_BITS+22+7)/8)*8;
    localparam int unsigned OUT_USED = 2*SAMPLE_BITS + 22;
    localparam int unsigned TW = pqi_pkg::STAMP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_MODE,
        ST_PRESS,
        ST_DIV,
        ST_OUT
    } state_t;

    // Configuration registers.
    logic [pqi_pkg::LEVEL_W-1:0] disconnect_reg;
    logic [pqi_pkg::LEVEL_W-1:0] sw_sleeve_reg;
    logic [pqi_pkg::LEVEL_W-1:0] tip_low_reg;
    logic [pqi_pkg::LEVEL_W-1:0] tip_high_reg;
    logic [pqi_pkg::LEVEL_W-1:0] heel_reg;
    logic [pqi_pkg::LEVEL_W-1:0] toe_reg;
    logic [pqi_pkg::HOLD_W-1:0]  mode_hold_reg;
    logic [pqi_pkg::HOLD_W-1:0]  press_hold_reg;

    // Request capture and block state.
    state_t                      state_reg;
    logic [SW-1:0]               sleeve_in_reg;
    logic [SW-1:0]               tip_in_reg;
    logic [TW-1:0]               now_reg;
    logic [SW-1:0]               sleeve_avg_reg;
    logic [SW-1:0]               tip_avg_reg;
    logic                        primed_reg;
    pqi_pkg::pedal_mode_t        cand_mode_reg;
    logic [TW-1:0]               mode_stamp_reg;
    pqi_pkg::pedal_mode_t        acc_mode_reg;
    logic                        cand_press_reg;
    logic                        acc_press_reg;
    logic [TW-1:0]               press_stamp_reg;
    logic                        mode_chg_reg;
    logic                        press_chg_reg;
    logic [pqi_pkg::POS_W-1:0]   pos_reg;

    // Output register.
    logic                        m_valid_reg;
    logic [OUT_USED-1:0]         m_data_reg;

    // Combinational helpers.
    logic [SW+1:0]               sleeve_sum;
    logic [SW+1:0]               tip_sum;
    logic [CW-1:0]               s_ext;
    logic [CW-1:0]               t_ext;
    logic [CW-1:0]               disc_ext;
    logic [CW-1:0]               sws_ext;
    logic [CW-1:0]               tlo_ext;
    logic [CW-1:0]               thi_ext;
    logic [CW-1:0]               heel_ext;
    logic [CW-1:0]               toe_ext;
    pqi_pkg::pedal_mode_t        detected;
    logic                        press_now;
    logic                        mode_cand_moves;
    logic                        press_cand_moves;
    logic [TW-1:0]               ts_stamp;
    logic [pqi_pkg::HOLD_W-1:0]  ts_hold;
    logic [TW-1:0]               ts_diff;
    logic                        ts_held;
    logic [CW-1:0]               pos_num;
    logic [CW-1:0]               pos_den;
    logic                        pos_live;
    logic                        pos_full;
    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic [pqi_pkg::FRAC_BITS-1:0] div_quo;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(OUT_W-OUT_USED){1'b0}}, m_data_reg};

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disconnect_reg <= pqi_pkg::RST_DISCONNECT;
            sw_sleeve_reg  <= pqi_pkg::RST_SWITCH_SLEEVE;
            tip_low_reg    <= pqi_pkg::RST_SWITCH_TIP_LO;
            tip_high_reg   <= pqi_pkg::RST_SWITCH_TIP_HI;
            heel_reg       <= pqi_pkg::RST_HEEL;
            toe_reg        <= pqi_pkg::RST_TOE;
            mode_hold_reg  <= pqi_pkg::RST_MODE_HOLD;
            press_hold_reg <= pqi_pkg::RST_PRESS_HOLD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pqi_pkg::REG_DISCONNECT:    disconnect_reg <= cfg_data[pqi_pkg::LEVEL_W-1:0];
                pqi_pkg::REG_SWITCH_SLEEVE: sw_sleeve_reg  <= cfg_data[pqi_pkg::LEVEL_W-1:0];
                pqi_pkg::REG_SWITCH_TIP_LO: tip_low_reg    <= cfg_data[pqi_pkg::LEVEL_W-1:0];
                pqi_pkg::REG_SWITCH_TIP_HI: tip_high_reg   <= cfg_data[pqi_pkg::LEVEL_W-1:0];
                pqi_pkg::REG_HEEL:          heel_reg       <= cfg_data[pqi_pkg::LEVEL_W-1:0];
                pqi_pkg::REG_TOE:           toe_reg        <= cfg_data[pqi_pkg::LEVEL_W-1:0];
                pqi_pkg::REG_MODE_HOLD:     mode_hold_reg  <= cfg_data;
                pqi_pkg::REG_PRESS_HOLD:    press_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Filter update: floor((3 * old + new) / 4).
    always_comb begin
        sleeve_sum = ({2'b00, sleeve_avg_reg} << 1) + {2'b00, sleeve_avg_reg}
                   + {2'b00, sleeve_in_reg};
        tip_sum    = ({2'b00, tip_avg_reg} << 1) + {2'b00, tip_avg_reg}
                   + {2'b00, tip_in_reg};
    end

    // Threshold comparisons at a common width.
    always_comb begin
        s_ext    = CW'(sleeve_avg_reg);
        t_ext    = CW'(tip_avg_reg);
        disc_ext = CW'(disconnect_reg);
        sws_ext  = CW'(sw_sleeve_reg);
        tlo_ext  = CW'(tip_low_reg);
        thi_ext  = CW'(tip_high_reg);
        heel_ext = CW'(heel_reg);
        toe_ext  = CW'(toe_reg);

        if (s_ext > disc_ext && t_ext > disc_ext) begin
            detected = pqi_pkg::MODE_NONE;
        end else if (s_ext < sws_ext && (t_ext < tlo_ext || t_ext > thi_ext)) begin
            detected = pqi_pkg::MODE_SWITCH;
        end else begin
            detected = pqi_pkg::MODE_EXPR;
        end
        press_now = t_ext < tlo_ext;
    end

    // Shared timestamp unit: wrapping age of a candidate against its hold time.
    always_comb begin
        mode_cand_moves  = detected != cand_mode_reg;
        press_cand_moves = press_now != cand_press_reg;
        if (state_reg == ST_MODE) begin
            ts_stamp = mode_cand_moves ? now_reg : mode_stamp_reg;
            ts_hold  = mode_hold_reg;
        end else begin
            ts_stamp = press_cand_moves ? now_reg : press_stamp_reg;
            ts_hold  = press_hold_reg;
        end
        ts_diff = now_reg - ts_stamp;
        ts_held = ts_diff >= {{(TW-pqi_pkg::HOLD_W){1'b0}}, ts_hold};
    end

    // Position operands: magnitudes of (sleeve - heel) and (toe - heel).
    always_comb begin
        pos_num  = '0;
        pos_den  = '0;
        pos_live = 1'b0;
        if (s_ext > heel_ext && toe_ext > heel_ext) begin
            pos_num  = s_ext - heel_ext;
            pos_den  = toe_ext - heel_ext;
            pos_live = 1'b1;
        end else if (s_ext < heel_ext && toe_ext < heel_ext) begin
            pos_num  = heel_ext - s_ext;
            pos_den  = heel_ext - toe_ext;
            pos_live = 1'b1;
        end
        pos_full  = pos_num >= pos_den;
        div_start = (state_reg == ST_PRESS) && (acc_mode_reg == pqi_pkg::MODE_EXPR)
                  && pos_live && !pos_full;
    end

    pqi_div #(
        .DATA_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (pos_num),
        .den      (pos_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer, state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sleeve_avg_reg  <= '0;
            tip_avg_reg     <= '0;
            primed_reg      <= 1'b0;
            cand_mode_reg   <= pqi_pkg::MODE_NONE;
            mode_stamp_reg  <= '0;
            acc_mode_reg    <= pqi_pkg::MODE_NONE;
            cand_press_reg  <= 1'b0;
            acc_press_reg   <= 1'b0;
            press_stamp_reg <= '0;
            mode_chg_reg    <= 1'b0;
            press_chg_reg   <= 1'b0;
            pos_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // A taken result clears valid unless the next one loads in this cycle.
            if (m_valid_reg && m_tready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        sleeve_in_reg <= s_tdata[SW-1:0];
                        tip_in_reg    <= s_tdata[2*SW-1:SW];
                        now_reg       <= s_tdata[2*SW+TW-1:2*SW];
                        state_reg     <= ST_FILT;
                    end
                end
                ST_FILT: begin
                    if (primed_reg) begin
                        sleeve_avg_reg <= sleeve_sum[SW+1:2];
                        tip_avg_reg    <= tip_sum[SW+1:2];
                    end else begin
                        sleeve_avg_reg <= sleeve_in_reg;
                        tip_avg_reg    <= tip_in_reg;
                    end
                    primed_reg    <= 1'b1;
                    mode_chg_reg  <= 1'b0;
                    press_chg_reg <= 1'b0;
                    pos_reg       <= '0;
                    state_reg     <= ST_MODE;
                end
                ST_MODE: begin
                    cand_mode_reg  <= detected;
                    mode_stamp_reg <= ts_stamp;
                    // A newly accepted mode drops any press state.
                    if (detected != acc_mode_reg && ts_held) begin
                        acc_mode_reg    <= detected;
                        press_chg_reg   <= acc_press_reg;
                        acc_press_reg   <= 1'b0;
                        cand_press_reg  <= 1'b0;
                        press_stamp_reg <= now_reg;
                        mode_chg_reg    <= 1'b1;
                    end
                    state_reg <= ST_PRESS;
                end
                ST_PRESS: begin
                    state_reg <= ST_OUT;
                    if (acc_mode_reg == pqi_pkg::MODE_SWITCH) begin
                        cand_press_reg  <= press_now;
                        press_stamp_reg <= ts_stamp;
                        if (press_now != acc_press_reg && ts_held) begin
                            acc_press_reg <= press_now;
                            press_chg_reg <= 1'b1;
                        end
                    end else if (acc_mode_reg == pqi_pkg::MODE_EXPR && pos_live) begin
                        if (pos_full) begin
                            pos_reg <= pqi_pkg::POS_ONE;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        pos_reg   <= {1'b0, div_quo};
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {tip_avg_reg, sleeve_avg_reg, pos_reg,
                                        press_chg_reg, mode_chg_reg, acc_press_reg,
                                        acc_mode_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A position is reported only in expression mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[21:5] == '0 ||
                         m_data_reg[1:0] == pqi_pkg::MODE_EXPR))
        else $error("position reported outside expression mode");

    // The position never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[21:5] <= pqi_pkg::POS_ONE))
        else $error("position above full toe");

    // A held press exists only in switch mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc_press_reg |-> (acc_mode_reg == pqi_pkg::MODE_SWITCH))
        else $error("press held outside switch mode");

    // The divider is idle whenever a new request can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("divider busy while accepting a request");
`endif

endmodule

[rtl/core/pqi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal input qualifier serial divider
// Restoring divider that forms the fractional quotient num / den in Q16,
// one quotient bit per cycle. The caller guarantees num < den.
// ----------------------------------------------------------------------------
module pqi_div #(
    parameter int unsigned DATA_W = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [DATA_W-1:0]              num,
    input  logic [DATA_W-1:0]              den,
    output logic                           busy,
    output logic                           done,
    output logic [pqi_pkg::FRAC_BITS-1:0]  quotient
);

    localparam int unsigned CNT_W = $clog2(pqi_pkg::FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(pqi_pkg::FRAC_BITS);

    logic [DATA_W:0]                   rem_reg;
    logic [DATA_W-1:0]                 den_reg;
    logic [pqi_pkg::FRAC_BITS-1:0]     quo_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic [DATA_W:0]                   rem_shift;
    logic                              fits;
    logic [DATA_W:0]                   rem_next;

    // One shift, compare and subtract per quotient bit.
    always_comb begin
        rem_shift = {rem_reg[DATA_W-1:0], 1'b0};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_next  = fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
    end

    // Sequencing of the iterations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[pqi_pkg::FRAC_BITS-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
